### hdl/life_pkg.sv
// life_pkg: shared types and constants for the bounded life grid block
// no dependencies; used by the channel interfaces, the top level and its checker
`default_nettype none

package life_pkg;

  localparam int CMD_W     = 2;
  localparam int IDX_W     = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int GEN_W     = 32;

  // reset value of both area registers before clamping
  localparam int DIM_RESET = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_ROWS = 1'd0,
    REG_ACTIVE_COLS = 1'd1
  } cfg_reg_t;

endpackage

`default_nettype wire

### hdl/life_cmd_if.sv
// life_cmd_if: command channel of the life grid block (valid/ready plus one command word)
// depends on life_pkg
`default_nettype none

interface life_cmd_if;
  import life_pkg::*;

  logic             valid;
  logic             ready;
  cmd_t             cmd;
  logic [IDX_W-1:0] row_index;
  logic [IDX_W-1:0] col_index;
  logic             cell_value;

  modport source (output valid, cmd, row_index, col_index, cell_value, input ready);
  modport sink   (input valid, cmd, row_index, col_index, cell_value, output ready);
endinterface

`default_nettype wire

### hdl/life_rsp_if.sv
// life_rsp_if: result channel of the life grid block (valid/ready plus one result word)
// depends on life_pkg
`default_nettype none

interface life_rsp_if;
  import life_pkg::*;

  logic             valid;
  logic             ready;
  logic             cell_state;
  logic [GEN_W-1:0] generation;

  modport source (output valid, cell_state, generation, input ready);
  modport sink   (input valid, cell_state, generation, output ready);
endinterface

`default_nettype wire

### hdl/life_automaton_grid_step.sv
// life_automaton_grid_step: bounded B3/S23 life grid held in a row-wide memory
// depends on life_pkg, life_cmd_if, life_rsp_if
//
//   channel | role    | word
//   --------+---------+-------------------------------------------
//   req     | sink    | cmd, row_index, col_index, cell_value
//   rsp     | source  | cell_state, generation
//   cfg     | write   | cfg_we, cfg_addr, cfg_wdata (no read-back)
//
// write and read commands step through row read, row modify/write and result load
// advance streams one row a cycle off the memory's read port through a three-row window,
// each new row written back on the separate write port two rows behind the read
// clear zeroes one row per cycle
// after reset a clearing pass over all MAX_ROWS rows runs with req.ready low
// one command at a time; a waiting result in rsp does not block the next accept
`default_nettype none

module life_automaton_grid_step #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire                         clk,
  input  wire                         rst,
  life_cmd_if.sink                    req,
  life_rsp_if.source                  rsp,
  input  wire                         cfg_we,
  input  wire [life_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire [life_pkg::CFG_W-1:0]   cfg_wdata
);
  import life_pkg::*;

  localparam int AW        = $clog2(MAX_ROWS);
  localparam int CW        = $clog2(MAX_COLS);
  localparam int CNT_W     = $clog2(MAX_ROWS + 2);
  localparam int ROWS_RST  = (MAX_ROWS < DIM_RESET) ? MAX_ROWS : DIM_RESET;
  localparam int COLS_RST  = (MAX_COLS < DIM_RESET) ? MAX_COLS : DIM_RESET;
  localparam logic [CNT_W-1:0] ADV_LAST = CNT_W'(MAX_ROWS + 1);
  localparam logic [CNT_W-1:0] CLR_LAST = CNT_W'(MAX_ROWS - 1);

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_ADV, ST_RDQ, ST_RDD, ST_RESP
  } state_t;

  // grid storage, one row per entry
  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_data;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [AW-1:0]       mem_raddr;
  logic [MAX_COLS-1:0] mem_wdata;

  state_t              state;
  logic [CNT_W-1:0]    cnt;
  logic                pend;
  cmd_t                cmd_q;
  logic [IDX_W-1:0]    row_q;
  logic [IDX_W-1:0]    col_q;
  logic                val_q;
  logic [CFG_W-1:0]    nr;
  logic [CFG_W-1:0]    nc;
  logic [GEN_W-1:0]    gen;
  logic [MAX_COLS-1:0] prev_row;
  logic [MAX_COLS-1:0] cur_row;
  logic                res_cell;
  logic                out_valid;
  logic                out_cell;
  logic [GEN_W-1:0]    out_gen;

  logic [MAX_COLS-1:0] col_mask;
  logic [MAX_COLS-1:0] in_row;
  logic [MAX_COLS-1:0] life_row;
  logic [MAX_COLS+1:0] pad_p;
  logic [MAX_COLS+1:0] pad_c;
  logic [MAX_COLS+1:0] pad_n;
  logic                in_area;
  logic [AW-1:0]       row_addr;
  logic [CW-1:0]       col_sel;
  logic [MAX_COLS-1:0] row_mod;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
    logic [CFG_W-1:0] r;
    if (v == '0) r = CFG_W'(1);
    else if (32'(v) > maxv) r = CFG_W'(maxv);
    else r = v;
    return r;
  endfunction

  assign row_addr = AW'(row_q);
  assign col_sel  = CW'(col_q);
  assign in_area  = (CFG_W'(row_q) < nr) && (CFG_W'(col_q) < nc);

  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      col_mask[j] = (32'(j) < 32'(nc));
    end
  end

  // row arriving from memory this cycle is row cnt-1; rows past the area are dead
  assign in_row = (cnt != '0 && 32'(cnt) <= 32'(nr)) ? (rd_data & col_mask) : '0;

  assign pad_p = {1'b0, prev_row, 1'b0};
  assign pad_c = {1'b0, cur_row, 1'b0};
  assign pad_n = {1'b0, in_row, 1'b0};

  // new value of row cnt-2 from its old neighbours
  always_comb begin
    logic [3:0] n;
    for (int j = 0; j < MAX_COLS; j++) begin
      n = 4'(pad_p[j]) + 4'(pad_p[j+1]) + 4'(pad_p[j+2])
        + 4'(pad_c[j]) + 4'(pad_c[j+2])
        + 4'(pad_n[j]) + 4'(pad_n[j+1]) + 4'(pad_n[j+2]);
      life_row[j] = (n == 4'd3) || ((n == 4'd2) && cur_row[j]);
    end
  end

  always_comb begin
    row_mod          = rd_data;
    row_mod[col_sel] = val_q;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row_addr;
    mem_wdata = row_mod;
    mem_raddr = row_addr;
    unique case (state)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cnt);
        mem_wdata = '0;
      end
      ST_ADV: begin
        mem_raddr = AW'(cnt);
        mem_we    = (cnt >= CNT_W'(2));
        mem_waddr = AW'(cnt - CNT_W'(2));
        mem_wdata = (32'(cnt) < 32'(nr) + 2) ? (life_row & col_mask) : '0;
      end
      ST_RDD: begin
        mem_we = (cmd_q == CMD_WRITE) && in_area;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      cnt       <= '0;
      pend      <= 1'b0;
      nr        <= CFG_W'(ROWS_RST);
      nc        <= CFG_W'(COLS_RST);
      gen       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_addr))
          REG_ACTIVE_ROWS: nr <= clamp_dim(cfg_wdata, MAX_ROWS);
          REG_ACTIVE_COLS: nc <= clamp_dim(cfg_wdata, MAX_COLS);
          default: ;
        endcase
      end
      // the result state below decides the word register itself
      if (rsp.ready && state != ST_RESP) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLR: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CLR_LAST) begin
            state <= pend ? ST_RDQ : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            cmd_q <= req.cmd;
            row_q <= req.row_index;
            col_q <= req.col_index;
            val_q <= req.cell_value;
            cnt   <= '0;
            pend  <= 1'b1;
            prev_row <= '0;
            cur_row  <= '0;
            priority case (req.cmd)
              CMD_ADVANCE: state <= ST_ADV;
              CMD_CLEAR:   state <= ST_CLR;
              default:     state <= ST_RDQ;
            endcase
          end
        end
        ST_ADV: begin
          prev_row <= cur_row;
          cur_row  <= in_row;
          cnt      <= cnt + CNT_W'(1);
          if (cnt == ADV_LAST) begin
            gen   <= gen + GEN_W'(1);
            state <= ST_RDQ;
          end
        end
        ST_RDQ: begin
          state <= ST_RDD;
        end
        ST_RDD: begin
          res_cell <= (cmd_q == CMD_WRITE) ? (in_area & val_q) : (in_area & rd_data[col_sel]);
          state    <= ST_RESP;
        end
        ST_RESP: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_cell  <= res_cell;
            out_gen   <= gen;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign req.ready      = (state == ST_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.cell_state = out_cell;
  assign rsp.generation = out_gen;

endmodule

`default_nettype wire

### hdl/life_chk.sv
// life_chk: port-level checks for life_automaton_grid_step, attached by bind
// depends on life_pkg and on the top level's port names
`default_nettype none

module life_chk (
  input wire                       clk,
  input wire                       rst,
  input wire                       req_valid,
  input wire                       req_ready,
  input wire                       rsp_valid,
  input wire                       rsp_ready,
  input wire                       rsp_cell_state,
  input wire [life_pkg::GEN_W-1:0] rsp_generation
);
  import life_pkg::*;

  // a stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_generation)
      && $stable(rsp_cell_state))
    else $error("result word changed while stalled");

  // one command at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("command accepted while previous one in flight");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result pending after reset");

  // generation only moves together with a loaded result
  a_gen_with_word: assert property (@(posedge clk) disable iff (rst)
    !$stable(rsp_generation) |-> rsp_valid)
    else $error("generation changed without a result word");

endmodule

bind life_automaton_grid_step life_chk u_life_chk (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_cell_state (rsp.cell_state),
  .rsp_generation (rsp.generation)
);

`default_nettype wire
